/* rtl/mac_grid_pressure_projection_macros.svh */
// assertion macros for the mac grid pressure projection block
// used by the top level; relies on the clock and reset names of that module
`ifndef MAC_GRID_PRESSURE_PROJECTION_MACROS_SVH
`define MAC_GRID_PRESSURE_PROJECTION_MACROS_SVH

`ifndef ASSERT_OFF

`define MGPP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define MGPP_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`define MGPP_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`else

`define MGPP_ASSERT(label, prop, msg)

`define MGPP_ASSERT_IMP(label, cond, prop, msg)

`define MGPP_ASSERT_NEXT(label, cond, prop, msg)

`endif

`endif

/* rtl/mgpp_pkg.sv */
// shared types and constants of the mac grid pressure projection block
// no dependencies
package mgpp_pkg;

   localparam int DATA_W  = 32;
   localparam int SCALE_W = 32;
   localparam int DIM_W   = 11;
   localparam int FRAC_W  = 24;
   localparam int PROD_W  = DATA_W + SCALE_W;
   localparam int Q_W     = PROD_W + 1 - FRAC_W;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 32;

   localparam logic [CSR_AW-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_GRAD_SCALE  = 2'd2;

   localparam logic [DIM_W-1:0] GRID_DIM_RESET = 11'd64;

   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (FRAC_W - 1);

   typedef struct packed {
      logic mag_load;
      logic prod_load;
      logic out_load;
   } adv_type;

endpackage

/* rtl/mgpp_line_store.sv */
// line store holding the pressures of the previous row, one entry per column
// synchronous memory, read-first, registered read data; no package use
module mgpp_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mgpp_correct.sv */
// one face of the gradient correction: difference, multiply, round and saturate
// three register stages; uses mgpp_pkg
module mgpp_correct (
   input  logic                           clock,
   input  mgpp_pkg::adv_type              adv,
   input  logic [mgpp_pkg::SCALE_W-1:0]   scale,
   input  logic [mgpp_pkg::DATA_W-1:0]    pressure,
   input  logic [mgpp_pkg::DATA_W-1:0]    ref_pressure,
   input  logic [mgpp_pkg::DATA_W-1:0]    vel,
   input  logic                           bypass,
   output logic [mgpp_pkg::DATA_W-1:0]    vel_out
);

   localparam int DW = mgpp_pkg::DATA_W;
   localparam int PW = mgpp_pkg::PROD_W;
   localparam int QW = mgpp_pkg::Q_W;
   localparam int RW = QW + 2;

   logic [DW:0]   diff;
   logic [DW:0]   diff_abs;
   logic [DW-1:0] mag_ff;
   logic          neg_a_ff;
   logic [DW-1:0] vel_a_ff;
   logic          byp_a_ff;

   logic [PW-1:0] prod_ff;
   logic          neg_b_ff;
   logic [DW-1:0] vel_b_ff;
   logic          byp_b_ff;

   logic [PW:0]   rnd_sum;
   logic [QW-1:0] quot;
   logic [RW-1:0] corr;
   logic [RW-1:0] vel_ext;
   logic [RW-1:0] res;
   logic [DW-1:0] sat;
   logic [DW-1:0] out_in;
   logic [DW-1:0] out_ff;

   // magnitude of the exact 33-bit difference fits in 32 bits
   assign diff     = {pressure[DW-1], pressure} - {ref_pressure[DW-1], ref_pressure};
   assign diff_abs = diff[DW] ? (~diff + (DW+1)'(1)) : diff;

   assign rnd_sum = {1'b0, prod_ff} + mgpp_pkg::ROUND_HALF;
   assign quot    = rnd_sum[PW:mgpp_pkg::FRAC_W];
   assign corr    = neg_b_ff ? (~{2'b00, quot} + RW'(1)) : {2'b00, quot};
   assign vel_ext = {{(RW-DW){vel_b_ff[DW-1]}}, vel_b_ff};
   assign res     = vel_ext - corr;

   always_comb begin
      if (!res[RW-1] && (res[RW-2:DW-1] != '0)) begin
         sat = {1'b0, {(DW-1){1'b1}}};
      end else if (res[RW-1] && (res[RW-2:DW-1] != '1)) begin
         sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         sat = res[DW-1:0];
      end
      out_in = byp_b_ff ? vel_b_ff : sat;
   end

   always_ff @(posedge clock) begin
      if (adv.mag_load) begin
         mag_ff   <= diff_abs[DW-1:0];
         neg_a_ff <= diff[DW];
         vel_a_ff <= vel;
         byp_a_ff <= bypass;
      end
      if (adv.prod_load) begin
         prod_ff  <= mag_ff * scale;
         neg_b_ff <= neg_a_ff;
         vel_b_ff <= vel_a_ff;
         byp_b_ff <= byp_a_ff;
      end
      if (adv.out_load) begin
         out_ff <= out_in;
      end
   end

   assign vel_out = out_ff;

endmodule

/* rtl/mac_grid_pressure_projection.sv */
// top level of the mac grid pressure projection block
// uses mgpp_pkg, mgpp_line_store, mgpp_correct and the assertion macro header
//
// Cells enter on the req_ stream in raster order, one word per cell holding
// the pressure and the u and v face velocities. Each cell gives one word on
// the rsp_ stream with the corrected u and v velocities; rsp_tlast marks the
// last cell of the grid. Grid size and gradient scale are set through the
// csr_ write port; the user must do so while no cell is in flight (unenforced).
// Throughput is one cell per cycle while rsp_tready is high, set by the single
// read and single write per cycle of the line store, which the next cell never waits on.
// From acceptance to rsp_tvalid a cell passes the input register and line store
// read, then difference, multiply, and round with saturation in the output register.
// When the receiver holds rsp_tready low the output register keeps its word;
// the stages behind it keep filling, and outside reset req_tready falls only when
// all four stages hold a cell.
// Reset clears the counters, the left pressure and all valid bits, holds
// req_tready low and loads the register defaults. The line store is not
// cleared: a row is always written before the row above reads it.
`include "mac_grid_pressure_projection_macros.svh"

module mac_grid_pressure_projection #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // cell_pressure, face_u_in, face_v_in
   input  logic [95:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // face_u_out, face_v_out
   output logic [63:0]                   rsp_tdata,
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [mgpp_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [mgpp_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int HW = $clog2(MAX_HEIGHT);
   localparam int DW = mgpp_pkg::DATA_W;

   function automatic logic [31:0] eff_last(input logic [mgpp_pkg::DIM_W-1:0] val,
                                            input int maxv);
      logic [31:0] result;
      if (val == '0) begin
         result = 32'd0;
      end else if (32'(val) > 32'(maxv)) begin
         result = 32'(maxv) - 32'd1;
      end else begin
         result = 32'(val) - 32'd1;
      end
      return result;
   endfunction

   localparam logic [CW-1:0] W_LAST_RST = CW'(eff_last(mgpp_pkg::GRID_DIM_RESET, MAX_WIDTH));
   localparam logic [HW-1:0] H_LAST_RST = HW'(eff_last(mgpp_pkg::GRID_DIM_RESET, MAX_HEIGHT));

   logic [CW-1:0]                w_last_ff;
   logic [HW-1:0]                h_last_ff;
   logic [mgpp_pkg::SCALE_W-1:0] scale_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;
   logic [DW-1:0] left_ff;

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic          ld1, ld2, ld3, ld4;
   logic          accept;
   logic          last_col, last_row;
   logic          frame_last;

   logic [DW-1:0] p_s1_ff, u_s1_ff, v_s1_ff, left_s1_ff;
   logic          byp_u_s1_ff, byp_v_s1_ff;
   logic          last_s1_ff, last_s2_ff, last_s3_ff, last_s4_ff;
   logic [DW-1:0] above_s1;

   logic [DW-1:0] in_p, in_u, in_v;
   logic [DW-1:0] u_out, v_out;

   mgpp_pkg::adv_type adv;

   assign in_p = req_tdata[31:0];
   assign in_u = req_tdata[63:32];
   assign in_v = req_tdata[95:64];

   // stage load enables, ready ripples back from the output register
   assign ld4        = !v4_ff || rsp_tready;
   assign ld3        = !v3_ff || ld4;
   assign ld2        = !v2_ff || ld3;
   assign ld1        = !v1_ff || ld2;
   assign req_tready = ld1 && !reset;
   assign accept     = req_tvalid && req_tready;

   assign adv.mag_load  = ld2;
   assign adv.prod_load = ld3;
   assign adv.out_load  = ld4;

   assign last_col   = col_ff >= w_last_ff;
   assign last_row   = row_ff >= h_last_ff;
   assign frame_last = last_col && last_row;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + HW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= W_LAST_RST;
         h_last_ff <= H_LAST_RST;
         scale_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            mgpp_pkg::CSR_GRID_WIDTH: begin
               w_last_ff <= CW'(eff_last(csr_wdata[mgpp_pkg::DIM_W-1:0], MAX_WIDTH));
            end
            mgpp_pkg::CSR_GRID_HEIGHT: begin
               h_last_ff <= HW'(eff_last(csr_wdata[mgpp_pkg::DIM_W-1:0], MAX_HEIGHT));
            end
            mgpp_pkg::CSR_GRAD_SCALE: begin
               scale_ff <= csr_wdata[mgpp_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            left_ff <= in_p;
         end
         if (ld1) begin
            v1_ff <= req_tvalid;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
         if (ld3) begin
            v3_ff <= v2_ff;
         end
         if (ld4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         p_s1_ff     <= in_p;
         u_s1_ff     <= in_u;
         v_s1_ff     <= in_v;
         left_s1_ff  <= left_ff;
         byp_u_s1_ff <= (col_ff == '0);
         byp_v_s1_ff <= (row_ff == '0);
         last_s1_ff  <= frame_last;
      end
      if (ld2) begin
         last_s2_ff <= last_s1_ff;
      end
      if (ld3) begin
         last_s3_ff <= last_s2_ff;
      end
      if (ld4) begin
         last_s4_ff <= last_s3_ff;
      end
   end

   mgpp_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .DW    (DW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (ld1),
      .rd_addr (col_ff),
      .rd_data (above_s1),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (in_p)
   );

   mgpp_correct u_correct_u (
      .clock        (clock),
      .adv          (adv),
      .scale        (scale_ff),
      .pressure     (p_s1_ff),
      .ref_pressure (left_s1_ff),
      .vel          (u_s1_ff),
      .bypass       (byp_u_s1_ff),
      .vel_out      (u_out)
   );

   mgpp_correct u_correct_v (
      .clock        (clock),
      .adv          (adv),
      .scale        (scale_ff),
      .pressure     (p_s1_ff),
      .ref_pressure (above_s1),
      .vel          (v_s1_ff),
      .bypass       (byp_v_s1_ff),
      .vel_out      (v_out)
   );

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {v_out, u_out};
   assign rsp_tlast  = last_s4_ff;

   `MGPP_ASSERT_IMP(a_no_overrun, req_tready && !ld4, !v1_ff || !v2_ff || !v3_ff, "no free stage")
   `MGPP_ASSERT_NEXT(a_frame_wrap, accept && frame_last, !(|{col_ff, row_ff}), "no frame wrap")
   `MGPP_ASSERT_NEXT(a_col0_bypass, accept && col_ff == '0, v1_ff && byp_u_s1_ff, "no u bypass")

endmodule
